[src/sss_pkg.sv]
// Package with the shared constants, codes and control types of sample_set_statistics.
package sss_pkg;

  // Sizes of the samples and of the set.
  localparam int SAMPLE_BITS = 16;
  localparam int MAX_COUNT   = 1024;
  localparam int CNT_W       = 11;
  localparam int SUM_W       = 27;
  localparam int SQ_W        = 41;
  localparam int MAG_W       = 26;
  localparam int PROD_W      = 52;
  localparam int DEN_W       = 20;
  localparam int DVD_W       = PROD_W + 16;
  localparam int QUO_W       = 48;
  localparam int RES_W       = 24;
  localparam int STEP_W      = 7;
  localparam int DIV_STEPS   = DVD_W;
  localparam int SQRT_STEPS  = QUO_W / 2;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SINGLE = 2'd1;
  localparam logic [1:0] ST_OVF    = 2'd2;

  // Controller states.
  typedef enum logic [8:0] {
    S_ACC  = 9'b000000001,
    S_MAG  = 9'b000000010,
    S_MUL  = 9'b000000100,
    S_SUB  = 9'b000001000,
    S_DIVM = 9'b000010000,
    S_MEAN = 9'b000100000,
    S_DIVV = 9'b001000000,
    S_SQLD = 9'b010000000,
    S_SQRT = 9'b100000000
  } sss_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic acc;
    logic mag;
    logic mul;
    logic sub;
    logic div_ld_mean;
    logic div_ld_var;
    logic div_step;
    logic mean_ld;
    logic sq_ld;
    logic sq_step;
    logic out_load;
  } sss_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic single;
    logic out_free;
  } sss_stat_t;

endpackage

[src/sss_ctrl.sv]
// Controller state machine that sequences accumulation, division and square root.
module sss_ctrl import sss_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last,
  output logic      in_stall,
  input  sss_stat_t stat,
  output sss_cmd_t  cmd
);

  sss_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  // Inputs are taken only while the set is open.
  assign in_stall = (state_r != S_ACC);

  // Next state, step counter and commands.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    unique case (state_r)
      S_ACC: begin
        if (in_valid) begin
          cmd.acc = 1'b1;
          if (in_last) state_nxt = S_MAG;
        end
      end
      S_MAG: begin
        cmd.mag   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SUB;
      end
      S_SUB: begin
        cmd.sub         = 1'b1;
        cmd.div_ld_mean = 1'b1;
        step_nxt        = '0;
        state_nxt       = S_DIVM;
      end
      S_DIVM: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = S_MEAN;
        end
      end
      S_MEAN: begin
        // The mean quotient is taken while the divider is loaded again.
        cmd.mean_ld    = 1'b1;
        cmd.div_ld_var = 1'b1;
        state_nxt      = stat.single ? S_SQRT : S_DIVV;
      end
      S_DIVV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = S_SQLD;
        end
      end
      S_SQLD: begin
        cmd.sq_ld = 1'b1;
        step_nxt  = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        // A single-sample set arrives here only to wait for the output.
        if (!stat.single && step_r != STEP_W'(SQRT_STEPS)) begin
          cmd.sq_step = 1'b1;
          step_nxt    = step_r + 1'b1;
        end else if (stat.out_free) begin
          cmd.out_load = 1'b1;
          step_nxt     = '0;
          state_nxt    = S_ACC;
        end
      end
      default: state_nxt = S_ACC;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACC;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // The block never takes a sample while the closing arithmetic runs.
  a_no_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc |-> state_r == S_ACC) else $error("sample taken while busy");
  // Divider steps never overlap square root steps.
  a_div_sq_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.div_step && cmd.sq_step)) else $error("divider and root step together");
  // A closing sample always starts the finishing sequence.
  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.acc && in_last) |=> state_r == S_MAG) else $error("finish did not start");

endmodule

[src/sss_dp.sv]
// Datapath: accumulators, products, shared divider, square root and output register.
module sss_dp import sss_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sss_cmd_t                cmd,
  output sss_stat_t               stat,
  input  logic [SAMPLE_BITS-1:0]  in_sample,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [23:0]             out_mean_q8,
  output logic [23:0]             out_stdev_q8,
  output logic [SAMPLE_BITS-1:0]  out_max_value,
  output logic [SAMPLE_BITS-1:0]  out_min_value,
  output logic [CNT_W-1:0]        out_sample_count,
  output logic [1:0]              out_status
);

  // Accumulator state.
  logic [CNT_W-1:0]       cnt_r;
  logic [SUM_W-1:0]       sum_r;
  logic [SQ_W-1:0]        sq_r;
  logic [SAMPLE_BITS-1:0] max_r, min_r;
  logic                   ovf_r;

  // Finishing arithmetic.
  logic                   neg_r;
  logic [MAG_W-1:0]       smag_r;
  logic [PROD_W-1:0]      a_r, b_r, v_r;
  logic [DEN_W-1:0]       d_r;
  logic [DVD_W-1:0]       dvd_r;
  logic [DEN_W-1:0]       dsr_r, rem_r;
  logic [QUO_W-1:0]       quo_r;
  logic [RES_W-1:0]       mean_r;
  logic [QUO_W-1:0]       sx_r, res_r, bit_r;

  // Output register.
  logic                   out_valid_r;
  logic [23:0]            o_mean_r, o_sd_r;
  logic [SAMPLE_BITS-1:0] o_max_r, o_min_r;
  logic [CNT_W-1:0]       o_cnt_r;
  logic [1:0]             o_st_r;

  logic [SAMPLE_BITS-1:0] mag;
  logic [SUM_W-1:0]       sum_neg;
  logic [DEN_W:0]         div_t;
  logic                   div_ge;
  logic [QUO_W-1:0]       sq_rb;
  logic                   room;
  logic [1:0]             st_code;

  assign stat.single   = (cnt_r < CNT_W'(2));
  assign stat.out_free = !out_valid_r || !out_stall;

  // Sample magnitude, negated sum and the divider and root step terms.
  always_comb begin
    mag     = in_sample[SAMPLE_BITS-1] ? (~in_sample + 1'b1) : in_sample;
    sum_neg = ~sum_r + 1'b1;
    room    = (cnt_r < CNT_W'(MAX_COUNT));
    div_t   = {rem_r, dvd_r[DVD_W-1]};
    div_ge  = (div_t >= {1'b0, dsr_r});
    sq_rb   = res_r + bit_r;
    if (ovf_r)             st_code = ST_OVF;
    else if (stat.single)  st_code = ST_SINGLE;
    else                   st_code = ST_OK;
  end

  // Accumulation of the open set and clearing when the result is loaded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
      sq_r  <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.out_load) begin
      cnt_r <= '0;
      sum_r <= '0;
      sq_r  <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.acc) begin
      if (room) begin
        cnt_r <= cnt_r + 1'b1;
        sum_r <= sum_r + {{(SUM_W-SAMPLE_BITS){in_sample[SAMPLE_BITS-1]}}, in_sample};
        sq_r  <= sq_r + SQ_W'(32'(mag) * 32'(mag));
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  // Maximum and minimum, loaded by the first sample of each set.
  always_ff @(posedge clk) begin
    if (cmd.acc && room) begin
      if (cnt_r == '0 || $signed(max_r) < $signed(in_sample)) max_r <= in_sample;
      if (cnt_r == '0 || $signed(in_sample) < $signed(min_r)) min_r <= in_sample;
    end
  end

  // Magnitude, products and numerator of the variance.
  always_ff @(posedge clk) begin
    if (cmd.mag) begin
      neg_r  <= sum_r[SUM_W-1];
      smag_r <= sum_r[SUM_W-1] ? sum_neg[MAG_W-1:0] : sum_r[MAG_W-1:0];
    end
    if (cmd.mul) begin
      a_r <= PROD_W'(cnt_r) * PROD_W'(sq_r);
      b_r <= PROD_W'(smag_r) * PROD_W'(smag_r);
      d_r <= DEN_W'(cnt_r) * (DEN_W'(cnt_r) - 1'b1);
    end
    if (cmd.sub) v_r <= (a_r > b_r) ? (a_r - b_r) : '0;
  end

  // Shared restoring divider, one quotient bit a cycle.
  always_ff @(posedge clk) begin
    if (cmd.div_ld_mean) begin
      dvd_r <= DVD_W'({smag_r, 8'd0});
      dsr_r <= DEN_W'(cnt_r);
      rem_r <= '0;
      quo_r <= '0;
    end else if (cmd.div_ld_var) begin
      dvd_r <= {v_r, 16'd0};
      dsr_r <= d_r;
      rem_r <= '0;
      quo_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= div_ge ? DEN_W'(div_t - {1'b0, dsr_r}) : div_t[DEN_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], div_ge};
    end
  end

  // Signed mean from the first quotient.
  always_ff @(posedge clk) begin
    if (cmd.mean_ld) mean_r <= neg_r ? (~quo_r[RES_W-1:0] + 1'b1) : quo_r[RES_W-1:0];
  end

  // Integer square root, one result bit a cycle.
  always_ff @(posedge clk) begin
    if (cmd.sq_ld) begin
      sx_r  <= quo_r;
      res_r <= '0;
      bit_r <= {2'b01, {(QUO_W-2){1'b0}}};
    end else if (cmd.sq_step) begin
      if (sx_r >= sq_rb) begin
        sx_r  <= sx_r - sq_rb;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // Output register, one result beat per set.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_mean_r <= mean_r;
      o_sd_r   <= stat.single ? '0 : res_r[RES_W-1:0];
      o_max_r  <= max_r;
      o_min_r  <= min_r;
      o_cnt_r  <= cnt_r;
      o_st_r   <= st_code;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mean_q8      = o_mean_r;
  assign out_stdev_q8     = o_sd_r;
  assign out_max_value    = o_max_r;
  assign out_min_value    = o_min_r;
  assign out_sample_count = o_cnt_r;
  assign out_status       = o_st_r;

  // The count never passes its saturation value.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_COUNT)) else $error("count beyond limit");
  // Overflow is flagged only once the count is saturated.
  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> cnt_r == CNT_W'(MAX_COUNT)) else $error("overflow without full count");
  // A result is loaded only when the previous one is gone, and then shows.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free ##1 out_valid_r) else $error("result overwritten");

endmodule

[src/sample_set_statistics.sv]
// Top level of sample_set_statistics: controller and datapath.
// Samples are taken one per cycle while a set is open; the beat with last set closes it.
// The block then stalls its input for the closing arithmetic: set-up states (S_MAG, S_MUL,
// S_SUB, S_MEAN, S_SQLD), two passes of a one-bit-per-cycle shared divider and a
// one-bit-per-cycle square root; for a single-sample set the second division and the root
// are skipped. The result waits in an output register; if the previous
// result is still held there, the block waits until it is taken. Samples past 1024 in a set
// are dropped and flagged with status 2.
module sample_set_statistics import sss_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SAMPLE_BITS-1:0]  in_sample,
  input  logic                    in_last,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [23:0]             out_mean_q8,
  output logic [23:0]             out_stdev_q8,
  output logic [SAMPLE_BITS-1:0]  out_max_value,
  output logic [SAMPLE_BITS-1:0]  out_min_value,
  output logic [CNT_W-1:0]        out_sample_count,
  output logic [1:0]              out_status
);

  sss_cmd_t  cmd;
  sss_stat_t stat;

  sss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  sss_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mean_q8      (out_mean_q8),
    .out_stdev_q8     (out_stdev_q8),
    .out_max_value    (out_max_value),
    .out_min_value    (out_min_value),
    .out_sample_count (out_sample_count),
    .out_status       (out_status)
  );

endmodule

[tb/tb_top.sv]
// Testbench for sample_set_statistics: random sample sets checked against a behavioral predictor.
`timescale 1ns / 100ps

module tb_top;
  import sss_pkg::*;

  // One input beat as queued for the driver.
  typedef struct packed {
    logic [15:0] sample;
    logic        last;
  } sample_beat_t;

  // One expected result.
  typedef struct packed {
    logic [23:0] mean_q8;
    logic [23:0] stdev_q8;
    logic [15:0] max_value;
    logic [15:0] min_value;
    logic [10:0] sample_count;
    logic [1:0]  status;
  } set_stats_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_sample;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic [23:0] out_mean_q8;
  logic [23:0] out_stdev_q8;
  logic [15:0] out_max_value;
  logic [15:0] out_min_value;
  logic [10:0] out_sample_count;
  logic [1:0]  out_status;

  sample_beat_t pending_beats[$];
  set_stats_t   expected_stats[$];
  int           error_count = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_off_cycles = 0;
  bit           drain_pause = 0;

  // Predictor state for the open set.
  int          acc_count;
  longint      acc_sum;
  longint      acc_sumsq;
  logic [15:0] acc_max;
  logic [15:0] acc_min;
  bit          acc_ovf;

  sample_set_statistics u_top (.*);

  // Clock.
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Integer square root, floored.
  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Accumulate one sample; on the closing beat push the expected statistics.
  task automatic accumulate_sample(input sample_beat_t b);
    longint          s;
    longint unsigned n;
    longint unsigned smag;
    longint unsigned mean;
    longint unsigned var_num;
    longint unsigned den;
    longint unsigned scaled;
    set_stats_t      st;
    s = longint'($signed(b.sample));
    if (acc_count < MAX_COUNT) begin
      if (acc_count == 0) begin
        acc_max = b.sample;
        acc_min = b.sample;
      end else begin
        if ($signed(b.sample) > $signed(acc_max)) acc_max = b.sample;
        if ($signed(b.sample) < $signed(acc_min)) acc_min = b.sample;
      end
      acc_sum += s;
      acc_sumsq += s * s;
      acc_count++;
    end else begin
      acc_ovf = 1;
    end
    if (!b.last) return;
    n = acc_count;
    smag = (acc_sum < 0) ? -acc_sum : acc_sum;
    mean = (smag << 8) / n;
    if (acc_sum < 0) mean = -mean;
    st.stdev_q8 = '0;
    if (n >= 2) begin
      var_num = n * acc_sumsq;
      var_num = (var_num > smag * smag) ? var_num - smag * smag : 0;
      den = n * (n - 1);
      scaled = ((var_num / den) << 16) + ((var_num % den) << 16) / den;
      st.stdev_q8 = 24'(isqrt(scaled));
    end
    st.mean_q8 = mean[23:0];
    st.max_value = acc_max;
    st.min_value = acc_min;
    st.sample_count = n[10:0];
    st.status = acc_ovf ? ST_OVF : (n < 2) ? ST_SINGLE : ST_OK;
    expected_stats.push_back(st);
    acc_count = 0;
    acc_sum = 0;
    acc_sumsq = 0;
    acc_ovf = 0;
  endtask

  // Queue one whole set of the given length.
  task automatic queue_set(input int len, input int kind);
    sample_beat_t b;
    for (int i = 0; i < len; i++) begin
      case (kind)
        0: b.sample = 16'($urandom);
        1: b.sample = 16'sh7fff;
        2: b.sample = 16'sh8000;
        3: b.sample = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        default: b.sample = 16'($urandom_range(0, 15) - 8);
      endcase
      b.last = (i == len - 1);
      pending_beats.push_back(b);
    end
  endtask

  // Driver: offers queued beats, idling at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) accumulate_sample({in_sample, in_last});
      if (pending_beats.size() > 0 && !drain_pause &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        sample_beat_t b;
        b = pending_beats.pop_front();
        in_valid <= 1;
        in_sample <= b.sample;
        in_last <= b.last;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // Receiver stall and long hold-off, counted here.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_stats.size() == 0) begin
        $error("result with no expectation waiting");
        error_count++;
      end else begin
        set_stats_t e;
        e = expected_stats.pop_front();
        if (out_mean_q8 !== e.mean_q8) begin
          $error("mean_q8 exp %0h got %0h", e.mean_q8, out_mean_q8);
          error_count++;
        end
        if (out_stdev_q8 !== e.stdev_q8) begin
          $error("stdev_q8 exp %0h got %0h", e.stdev_q8, out_stdev_q8);
          error_count++;
        end
        if (out_max_value !== e.max_value) begin
          $error("max_value exp %0h got %0h", e.max_value, out_max_value);
          error_count++;
        end
        if (out_min_value !== e.min_value) begin
          $error("min_value exp %0h got %0h", e.min_value, out_min_value);
          error_count++;
        end
        if (out_sample_count !== e.sample_count) begin
          $error("sample_count exp %0h got %0h", e.sample_count, out_sample_count);
          error_count++;
        end
        if (out_status !== e.status) begin
          $error("status exp %0h got %0h", e.status, out_status);
          error_count++;
        end
      end
    end
  end

  // Wait until the driver has handed over all queued beats and results are in.
  task automatic wait_drained();
    while (pending_beats.size() > 0 || in_valid || expected_stats.size() > 0)
      @(posedge clk);
  endtask

  // Random sets: mostly short, a few long.
  task automatic queue_random_sets(input int beats);
    int total;
    int len;
    int r;
    total = 0;
    while (total < beats) begin
      r = $urandom_range(0, 99);
      if (r < 10) len = 1;
      else if (r < 85) len = $urandom_range(2, 20);
      else len = $urandom_range(21, 120);
      queue_set(len, $urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 4));
      total += len;
    end
  endtask

  // Stimulus and phases.
  initial begin
    in_valid = 0;
    in_sample = 0;
    in_last = 0;
    out_stall = 0;
    acc_count = 0;
    acc_sum = 0;
    acc_sumsq = 0;
    acc_ovf = 0;
    rst_n = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    // Directed sets: single samples, extremes, mixed extremes, small values, random values.
    queue_set(1, 1);
    queue_set(1, 2);
    queue_set(2, 1);
    queue_set(2, 2);
    queue_set(4, 3);
    queue_set(3, 4);
    queue_set(5, 0);
    queue_set(2, 0);
    wait_drained();
    // Past the count limit with extremes.
    queue_set(1026, 3);
    wait_drained();
    // Long hold-off while the sender keeps offering.
    hold_off_cycles = 1500;
    queue_random_sets(60);
    wait_drained();
    // Sender pauses until everything is back.
    drain_pause = 1;
    queue_random_sets(30);
    repeat (20) @(posedge clk);
    drain_pause = 0;
    wait_drained();
    // Idling phases.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 48 : (ph == 3) ? 21 : 0;
      recv_stall_pct = (ph == 2) ? 48 : (ph == 3) ? 21 : 0;
      queue_random_sets(40);
      wait_drained();
    end
    repeat (300) @(posedge clk);
    if (error_count == 0 && expected_stats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
